FILE: hw/rtl/rnrd_pkg.sv
// ----------------------------------------------------------------------------
// rnrd_pkg
// Shared types, codes and the microcode table for the raster run decoder.
// ----------------------------------------------------------------------------
package rnrd_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_ROW   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL = 2'd0;
  localparam logic [1:0] ST_BINS  = 2'd1;
  localparam logic [1:0] ST_ROWS  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [1:0] CFG_MAP_LOW   = 2'd1;
  localparam logic [1:0] CFG_MAP_HIGH  = 2'd2;

  // Field widths.
  localparam int SideW = 10;
  localparam int AddrW = 18;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    S_FETCH,
    S_CLEAR,
    S_ROW_MUL,
    S_ROW_LOAD,
    S_ERR_ROWS,
    S_PIXEL,
    S_ERR_BINS
  } step_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic       fetch;      // take an input beat and dispatch on it
    logic       clear;      // frame start: clear row state
    logic       row_mul;    // form the row base product, count the row
    logic       row_load;   // load the row base from the product
    logic       emit;       // write a result beat, wait for a free output
    logic       pix;        // the result is a pixel, not an error
    logic [1:0] err_status; // status of an error result
    logic       loop;       // repeat this step while the run has pixels left
    step_t      next;       // following step
  } ctrl_t;

  // Conditions that the datapath hands back to the sequencer.
  typedef struct packed {
    logic  in_fire;  // input beat taken this cycle
    logic  out_free; // output register can take a beat this cycle
    logic  run_more; // more than one pixel of the run remains
    step_t target;   // dispatch target for the fetched item
  } cond_t;

  // Microcode table.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{fetch: 1'b0, clear: 1'b0, row_mul: 1'b0, row_load: 1'b0, emit: 1'b0,
          pix: 1'b0, err_status: ST_PIXEL, loop: 1'b0, next: S_FETCH};
    case (step)
      S_FETCH:    w.fetch = 1'b1;
      S_CLEAR:    w.clear = 1'b1;
      S_ROW_MUL: begin
        w.row_mul = 1'b1;
        w.next    = S_ROW_LOAD;
      end
      S_ROW_LOAD: w.row_load = 1'b1;
      S_ERR_ROWS: begin
        w.emit       = 1'b1;
        w.err_status = ST_ROWS;
      end
      S_PIXEL: begin
        w.emit = 1'b1;
        w.pix  = 1'b1;
        w.loop = 1'b1;
      end
      S_ERR_BINS: begin
        w.emit       = 1'b1;
        w.err_status = ST_BINS;
      end
      default:    w.next = S_FETCH;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/rnrd_if.sv
// ----------------------------------------------------------------------------
// rnrd_if
// Valid/ready channels for input items and result beats of the decoder.
// ----------------------------------------------------------------------------
interface rnrd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] run_byte;

  modport source (output valid, output op, output run_byte, input ready);
  modport sink   (input valid, input op, input run_byte, output ready);
endinterface

interface rnrd_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] pixel_address;
  logic [7:0]  pixel_value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output pixel_address, output pixel_value,
                  output status, output last, input ready);
  modport sink   (input valid, input pixel_address, input pixel_value,
                  input status, input last, output ready);
endinterface

FILE: hw/rtl/rnrd_seq.sv
// ----------------------------------------------------------------------------
// rnrd_seq
// Step counter and microcode table that drive the decoder datapath.
// ----------------------------------------------------------------------------
module rnrd_seq
  import rnrd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cond_t cond,
  output ctrl_t ctrl
);

  step_t step;
  step_t step_next;

  // Current control word.
  assign ctrl = ucode(step);

  // Next step: dispatch on fetch, hold while the output is busy or the run
  // still has pixels, otherwise follow the word.
  always_comb begin
    step_next = ctrl.next;
    if (ctrl.fetch) begin
      step_next = cond.in_fire ? cond.target : S_FETCH;
    end else if (ctrl.emit && !cond.out_free) begin
      step_next = step;
    end else if (ctrl.loop && cond.run_more) begin
      step_next = step;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hw/rtl/raster_nibble_rle_decoder.sv
// ----------------------------------------------------------------------------
// raster_nibble_rle_decoder
// Expands run bytes of a square raster into pixel writes with rows flipped.
//
//   channel  dir  beat contents
//   item     in   op, run_byte
//   result   out  pixel_address, pixel_value, status, last
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A run byte goes through a fetch step and one pixel step per pixel; the
// microcode emits one pixel per step through the output register. A row
// start runs fetch, multiply and load steps, a frame start fetch and clear,
// an error result fetch and the error step; ignored items only fetch. Reset
// clears the row state and restores the registers to their defaults. A
// stalled result holds the pixel step until the output register is taken.
// ----------------------------------------------------------------------------
module raster_nibble_rle_decoder
  import rnrd_pkg::*;
#(
  parameter int MAX_ROWS = 512
)
(
  input  logic        clk,
  input  logic        rst,
  rnrd_in_if.sink     item,
  rnrd_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [SideW:0] MaxRows = (SideW + 1)'(MAX_ROWS);

  // Configuration registers.
  logic [SideW-1:0] side_cfg;
  logic [127:0]     code_map;

  // Row state.
  logic [SideW-1:0] rows_begun;
  logic [AddrW-1:0] row_base;
  logic [SideW-1:0] bin_count;
  logic             halted;

  // Item registers.
  logic [SideW-1:0] side;
  logic [SideW-1:0] mul_a;
  logic [AddrW-1:0] prod;
  logic [3:0]       remaining;
  logic [7:0]       value;

  // Output register.
  logic             out_valid;
  logic [AddrW-1:0] out_addr;
  logic [7:0]       out_value;
  logic [1:0]       out_status;
  logic             out_last;

  ctrl_t ctrl;
  cond_t cond;

  logic [SideW-1:0] side_now;
  logic [3:0]       run_len;
  logic [3:0]       code;
  logic             out_free;
  logic             emit_fire;

  rnrd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  assign run_len = item.run_byte[7:4];
  assign code    = item.run_byte[3:0];

  // Effective side length: zero acts as one, large values clamp.
  always_comb begin
    side_now = side_cfg;
    if (side_cfg == '0) begin
      side_now = SideW'(1);
    end else if ({1'b0, side_cfg} > MaxRows) begin
      side_now = MaxRows[SideW-1:0];
    end
  end

  // The input is only taken at a fetch step outside reset.
  assign item.ready = ctrl.fetch && !rst;
  assign out_free   = !out_valid || result.ready;
  assign emit_fire  = ctrl.emit && out_free;

  // Dispatch: classify the item against the current row state.
  always_comb begin
    cond.in_fire  = item.valid && item.ready;
    cond.out_free = out_free;
    cond.run_more = remaining != 4'd1;
    cond.target   = S_FETCH;
    if (item.op == OP_FRAME) begin
      cond.target = S_CLEAR;
    end else if (halted) begin
      cond.target = S_FETCH;
    end else if (item.op == OP_ROW) begin
      cond.target = (rows_begun >= side_now) ? S_ERR_ROWS : S_ROW_MUL;
    end else if (item.op == OP_RUN) begin
      if (rows_begun == '0 || run_len == 4'd0) begin
        cond.target = S_FETCH;
      end else if ({1'b0, bin_count} + (SideW + 1)'(run_len) > {1'b0, side_now}) begin
        cond.target = S_ERR_BINS;
      end else begin
        cond.target = S_PIXEL;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= SideW'(512);
      code_map <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: side_cfg         <= cfg_data[SideW-1:0];
        CFG_MAP_LOW:  code_map[63:0]   <= cfg_data;
        CFG_MAP_HIGH: code_map[127:64] <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Item latch and row base multiply.
  always_ff @(posedge clk) begin
    if (cond.in_fire) begin
      side      <= side_now;
      mul_a     <= side_now - SideW'(1) - rows_begun;
      remaining <= run_len;
      value     <= code_map[{code, 3'b000} +: 8];
    end else if (ctrl.pix && emit_fire) begin
      remaining <= remaining - 4'd1;
    end
    if (ctrl.row_mul) begin
      prod <= AddrW'(mul_a * side);
    end
  end

  // Row state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_begun <= '0;
      row_base   <= '0;
      bin_count  <= '0;
      halted     <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        rows_begun <= '0;
        row_base   <= '0;
        bin_count  <= '0;
        halted     <= 1'b0;
      end
      if (ctrl.row_mul) begin
        rows_begun <= rows_begun + SideW'(1);
        bin_count  <= '0;
      end
      if (ctrl.row_load) begin
        row_base <= prod;
      end
      if (emit_fire) begin
        if (ctrl.pix) begin
          bin_count <= bin_count + SideW'(1);
        end else begin
          halted <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (ctrl.pix) begin
        out_addr   <= row_base + AddrW'(bin_count);
        out_value  <= value;
        out_status <= ST_PIXEL;
        out_last   <= remaining == 4'd1;
      end else begin
        out_addr   <= '0;
        out_value  <= '0;
        out_status <= ctrl.err_status;
        out_last   <= 1'b1;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.pixel_address = out_addr;
  assign result.pixel_value   = out_value;
  assign result.status        = out_status;
  assign result.last          = out_last;

endmodule
